// ===== design/csmm_pkg.sv =====
`default_nettype none

package csmm_pkg;

  // Widths of samples and of the sum of squares
  localparam int SAMPLE_W = 32;
  localparam int ACC_W    = 64;

  // Fixed field widths
  localparam int PIX_W   = 32;
  localparam int DIM_W   = 16;
  localparam int COUNT_W = 48;
  localparam int RMS_W   = 31;
  localparam int IDX_W   = 2;
  localparam int PROD_W  = 2 * PIX_W;

  // Square root digit steps and shared subtractor width
  localparam int SQ_STEPS = (ACC_W + 1) / 2;
  localparam int RAD_W    = 2 * SQ_STEPS;
  localparam int SUB_W    = (COUNT_W + 1 > SQ_STEPS + 3) ? COUNT_W + 1 : SQ_STEPS + 3;
  localparam int STEP_W   = $clog2(ACC_W + 1);

  // Register indexes
  localparam logic [IDX_W-1:0] REG_COLUMNS = 2'd0;
  localparam logic [IDX_W-1:0] REG_ROWS    = 2'd1;
  localparam logic [IDX_W-1:0] REG_SLICES  = 2'd2;

  // Codes
  localparam logic signed [PIX_W-1:0] SENTINEL = -32'sd256000000;
  localparam logic signed [PIX_W-1:0] MOST_POS = 32'sh7FFF_FFFF;
  localparam logic signed [PIX_W-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic [COUNT_W-1:0]      COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [ACC_W:0]          ACC_LIM = {1'b0, {ACC_W{1'b1}}};
  localparam logic [RMS_W-1:0]        RMS_MAX = {RMS_W{1'b1}};

endpackage

`default_nettype wire

// ===== design/csmm_channels.sv =====
`default_nettype none

// Pixel channel
interface csmm_pix_if;
  logic                               valid;
  logic                               ready;
  logic signed [csmm_pkg::PIX_W-1:0]  sample;
  logic                               is_nan;
  modport source (output valid, output sample, output is_nan, input ready);
  modport sink   (input valid, input sample, input is_nan, output ready);
endinterface

// Result channel
interface csmm_res_if;
  logic                                valid;
  logic                                ready;
  logic        [csmm_pkg::DIM_W-1:0]   slice_number;
  logic signed [csmm_pkg::PIX_W-1:0]   slice_min;
  logic signed [csmm_pkg::PIX_W-1:0]   slice_max;
  logic                                slice_has_valid;
  logic                                cube_done;
  logic signed [csmm_pkg::PIX_W-1:0]   cube_min;
  logic signed [csmm_pkg::PIX_W-1:0]   cube_max;
  logic        [csmm_pkg::COUNT_W-1:0] bad_pixels;
  logic        [csmm_pkg::COUNT_W-1:0] good_pixels;
  logic        [csmm_pkg::RMS_W-1:0]   rms_value;
  modport source (output valid, output slice_number, output slice_min, output slice_max,
                  output slice_has_valid, output cube_done, output cube_min,
                  output cube_max, output bad_pixels, output good_pixels,
                  output rms_value, input ready);
  modport sink   (input valid, input slice_number, input slice_min, input slice_max,
                  input slice_has_valid, input cube_done, input cube_min,
                  input cube_max, input bad_pixels, input good_pixels,
                  input rms_value, output ready);
endinterface

// Configuration write channel
interface csmm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [csmm_pkg::IDX_W-1:0]       index;
  logic [csmm_pkg::DIM_W-1:0]       data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/cube_slice_min_max_rms_core.sv =====
`default_nettype none

// Channel | Direction | Transaction
// --------+-----------+--------------------------------------------------
// pix     | in        | one pixel: sample (Q23.8), is_nan
// res     | out       | one finished slice, with cube totals on the last
// cfg     | in        | register write: index 0 columns, 1 rows, 2 slices
//
// A pixel is captured, squared on the multiplier and accumulated, in that order;
// a pixel that ends a slice then loads the output register.
// Before that, the last pixel of a cube with a valid pixel runs a restoring
// division and a digit-by-digit square root, both on one shared subtractor;
// when no pixel was valid, both are skipped.
// Reset (rst, synchronous) clears all statistics and sets each register to 1.
// A pixel may be taken while a result waits in the output register; a result
// that finds that register full holds the block until res.ready frees it.
module cube_slice_min_max_rms_core (
  input  wire logic   clk,
  input  wire logic   rst,
  csmm_pix_if.sink    pix,
  csmm_res_if.source  res,
  csmm_cfg_if.sink    cfg
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_SQUARE = 6'b000010,
    ST_ACCUM  = 6'b000100,
    ST_DIV    = 6'b001000,
    ST_SQRT   = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t state;

  // Configuration and derived slice size
  logic [csmm_pkg::DIM_W-1:0]   columns, rows, slices;
  logic [csmm_pkg::DIM_W-1:0]   cols_eff, rows_eff, slices_eff;
  logic [2*csmm_pkg::DIM_W-1:0] per_slice;

  // Captured pixel and its square
  logic signed [csmm_pkg::PIX_W-1:0] sample_q;
  logic                              bad_q;
  logic [csmm_pkg::PROD_W-1:0]       square;

  // Running statistics
  logic [2*csmm_pkg::DIM_W-1:0]      pixel_in_slice;
  logic [csmm_pkg::DIM_W-1:0]        current_slice;
  logic signed [csmm_pkg::PIX_W-1:0] slice_min, slice_max, cube_min, cube_max;
  logic                              slice_seen;
  logic [csmm_pkg::ACC_W-1:0]        square_sum;
  logic [csmm_pkg::COUNT_W-1:0]      valid_total, bad_total;
  logic                              last_q;

  // Divide and root datapath
  logic [csmm_pkg::ACC_W-1:0]    quot;
  logic [csmm_pkg::RAD_W-1:0]    rad;
  logic [csmm_pkg::SUB_W-1:0]    rem;
  logic [csmm_pkg::SQ_STEPS-1:0] root;
  logic [csmm_pkg::STEP_W-1:0]   step;

  // Output register
  logic                              out_valid;
  logic [csmm_pkg::DIM_W-1:0]        out_slice_number;
  logic signed [csmm_pkg::PIX_W-1:0] out_slice_min, out_slice_max;
  logic                              out_slice_has_valid, out_cube_done;
  logic signed [csmm_pkg::PIX_W-1:0] out_cube_min, out_cube_max;
  logic [csmm_pkg::COUNT_W-1:0]      out_bad, out_good;
  logic [csmm_pkg::RMS_W-1:0]        out_rms;

  logic pix_take, out_free;
  logic signed [csmm_pkg::PIX_W-1:0] sample_ext;
  logic signed [csmm_pkg::PROD_W-1:0] square_full;
  logic [csmm_pkg::ACC_W:0]          sum_wide;
  logic [csmm_pkg::ACC_W-1:0]        sum_next;
  logic [csmm_pkg::COUNT_W-1:0]      valid_next;
  logic                              slice_end, cube_last;
  logic [csmm_pkg::SUB_W-1:0]        sub_a, sub_b;
  logic [csmm_pkg::SUB_W:0]          diff;
  logic                              sub_ge;
  logic [31:0]                       root_ext;
  logic [csmm_pkg::RMS_W-1:0]        rms_sat;

  assign cfg.ready = 1'b1;
  assign pix.ready = (state == ST_IDLE);
  assign pix_take  = pix.valid && (state == ST_IDLE);
  assign out_free  = !out_valid || res.ready;

  assign cols_eff   = (columns == '0) ? csmm_pkg::DIM_W'(1) : columns;
  assign rows_eff   = (rows == '0) ? csmm_pkg::DIM_W'(1) : rows;
  assign slices_eff = (slices == '0) ? csmm_pkg::DIM_W'(1) : slices;

  // Keep only the low sample bits, sign-extended
  assign sample_ext  = csmm_pkg::PIX_W'(signed'(pix.sample[csmm_pkg::SAMPLE_W-1:0]));
  assign square_full = sample_q * sample_q;

  // Saturating accumulate and counters
  assign sum_wide = (csmm_pkg::ACC_W + 1)'(square_sum) + (csmm_pkg::ACC_W + 1)'(square);
  assign sum_next = bad_q ? square_sum :
                    (sum_wide > csmm_pkg::ACC_LIM) ? csmm_pkg::ACC_W'(csmm_pkg::ACC_LIM)
                                                   : sum_wide[csmm_pkg::ACC_W-1:0];
  assign valid_next = (!bad_q && valid_total != csmm_pkg::COUNT_MAX) ?
                      valid_total + csmm_pkg::COUNT_W'(1) : valid_total;
  assign slice_end = ((2*csmm_pkg::DIM_W + 1)'(pixel_in_slice) + (2*csmm_pkg::DIM_W + 1)'(1))
                     >= (2*csmm_pkg::DIM_W + 1)'(per_slice);
  assign cube_last = ((csmm_pkg::DIM_W + 1)'(current_slice) + (csmm_pkg::DIM_W + 1)'(1))
                     >= (csmm_pkg::DIM_W + 1)'(slices_eff);

  // Shared compare-subtract unit for divide and root steps
  always_comb begin
    if (state == ST_SQRT) begin
      sub_a = {rem[csmm_pkg::SUB_W-3:0], rad[csmm_pkg::RAD_W-1 -: 2]};
      sub_b = csmm_pkg::SUB_W'({root, 2'b01});
    end else begin
      sub_a = {rem[csmm_pkg::SUB_W-2:0], quot[csmm_pkg::ACC_W-1]};
      sub_b = csmm_pkg::SUB_W'(valid_total);
    end
  end
  assign diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = !diff[csmm_pkg::SUB_W];

  // Clamp the root into the result field
  assign root_ext = 32'(root);
  assign rms_sat  = (root_ext > 32'(csmm_pkg::RMS_MAX)) ? csmm_pkg::RMS_MAX
                                                        : root_ext[csmm_pkg::RMS_W-1:0];

  // Configuration registers and slice size
  always_ff @(posedge clk) begin
    if (rst) begin
      columns <= csmm_pkg::DIM_W'(1);
      rows    <= csmm_pkg::DIM_W'(1);
      slices  <= csmm_pkg::DIM_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        csmm_pkg::REG_COLUMNS: columns <= cfg.data;
        csmm_pkg::REG_ROWS:    rows    <= cfg.data;
        csmm_pkg::REG_SLICES:  slices  <= cfg.data;
        default: ;
      endcase
    end
    per_slice <= cols_eff * rows_eff;
  end

  // Sequencer and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pixel_in_slice <= '0;
      current_slice  <= '0;
      slice_min      <= csmm_pkg::MOST_POS;
      slice_max      <= csmm_pkg::MOST_NEG;
      slice_seen     <= 1'b0;
      cube_min       <= csmm_pkg::MOST_POS;
      cube_max       <= csmm_pkg::MOST_NEG;
      square_sum     <= '0;
      valid_total    <= '0;
      bad_total      <= '0;
      last_q         <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // drop the result once taken, unless a new one replaces it
      if (out_valid && res.ready && state != ST_EMIT) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (pix_take) begin
            sample_q <= sample_ext;
            bad_q    <= pix.is_nan || (sample_ext == csmm_pkg::SENTINEL);
            state    <= ST_SQUARE;
          end
        end

        ST_SQUARE: begin
          square <= csmm_pkg::PROD_W'(square_full);
          state  <= ST_ACCUM;
        end

        ST_ACCUM: begin
          if (bad_q) begin
            if (bad_total != csmm_pkg::COUNT_MAX) bad_total <= bad_total + csmm_pkg::COUNT_W'(1);
          end else begin
            if (sample_q < slice_min) slice_min <= sample_q;
            if (sample_q > slice_max) slice_max <= sample_q;
            if (sample_q < cube_min) cube_min <= sample_q;
            if (sample_q > cube_max) cube_max <= sample_q;
            slice_seen <= 1'b1;
          end
          square_sum     <= sum_next;
          valid_total    <= valid_next;
          pixel_in_slice <= pixel_in_slice + (2*csmm_pkg::DIM_W)'(1);
          last_q         <= cube_last;
          quot           <= sum_next;
          rem            <= '0;
          root           <= '0;
          step           <= '0;
          priority if (!slice_end)             state <= ST_IDLE;
          else if (!cube_last)                 state <= ST_EMIT;
          else if (valid_next == '0)           state <= ST_EMIT;
          else                                 state <= ST_DIV;
        end

        ST_DIV: begin
          quot <= {quot[csmm_pkg::ACC_W-2:0], sub_ge};
          // hand the quotient to the root and restart the remainder after the last step
          if (step == csmm_pkg::STEP_W'(csmm_pkg::ACC_W - 1)) begin
            rad   <= csmm_pkg::RAD_W'({quot[csmm_pkg::ACC_W-2:0], sub_ge});
            rem   <= '0;
            step  <= '0;
            state <= ST_SQRT;
          end else begin
            rem  <= sub_ge ? diff[csmm_pkg::SUB_W-1:0] : sub_a;
            step <= step + csmm_pkg::STEP_W'(1);
          end
        end

        ST_SQRT: begin
          rem  <= sub_ge ? diff[csmm_pkg::SUB_W-1:0] : sub_a;
          root <= {root[csmm_pkg::SQ_STEPS-2:0], sub_ge};
          rad  <= {rad[csmm_pkg::RAD_W-3:0], 2'b00};
          step <= step + csmm_pkg::STEP_W'(1);
          if (step == csmm_pkg::STEP_W'(csmm_pkg::SQ_STEPS - 1)) state <= ST_EMIT;
        end

        ST_EMIT: begin
          if (out_free) begin
            out_valid           <= 1'b1;
            out_slice_number    <= current_slice;
            out_slice_min       <= slice_min;
            out_slice_max       <= slice_max;
            out_slice_has_valid <= slice_seen;
            out_cube_done       <= last_q;
            out_cube_min        <= last_q ? cube_min : '0;
            out_cube_max        <= last_q ? cube_max : '0;
            out_bad             <= last_q ? bad_total : '0;
            out_good            <= last_q ? valid_total : '0;
            out_rms             <= last_q ? rms_sat : '0;
            // clear the slice, and the cube after its last slice
            pixel_in_slice <= '0;
            slice_min      <= csmm_pkg::MOST_POS;
            slice_max      <= csmm_pkg::MOST_NEG;
            slice_seen     <= 1'b0;
            if (last_q) begin
              current_slice <= '0;
              cube_min      <= csmm_pkg::MOST_POS;
              cube_max      <= csmm_pkg::MOST_NEG;
              square_sum    <= '0;
              valid_total   <= '0;
              bad_total     <= '0;
            end else begin
              current_slice <= current_slice + csmm_pkg::DIM_W'(1);
            end
            state <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

  assign res.valid           = out_valid;
  assign res.slice_number    = out_slice_number;
  assign res.slice_min       = out_slice_min;
  assign res.slice_max       = out_slice_max;
  assign res.slice_has_valid = out_slice_has_valid;
  assign res.cube_done       = out_cube_done;
  assign res.cube_min        = out_cube_min;
  assign res.cube_max        = out_cube_max;
  assign res.bad_pixels      = out_bad;
  assign res.good_pixels     = out_good;
  assign res.rms_value       = out_rms;

  // A slice with no valid pixel reports the empty extremes
  a_empty_slice: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_slice_has_valid) |->
      (out_slice_min == csmm_pkg::MOST_POS && out_slice_max == csmm_pkg::MOST_NEG))
    else $error("empty slice reports non-empty extremes");

  // Cube totals appear only on the last slice of a cube
  a_totals_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_cube_done) |->
      (out_good == '0 && out_bad == '0 && out_rms == '0))
    else $error("cube totals on a non-final slice");

  // Cube extremes enclose those of its last slice
  a_cube_encloses: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_cube_done && out_slice_has_valid) |->
      (out_cube_min <= out_slice_min && out_cube_max >= out_slice_max))
    else $error("cube extremes do not enclose slice extremes");

  // An accepted pixel goes straight to the multiplier
  a_take_square: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready) |=> (state == ST_SQUARE))
    else $error("accepted pixel not squared next cycle");

  // A waiting result is not overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |=> ($stable(out_slice_number) && $stable(out_cube_done)))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`default_nettype none

module testbench;

  localparam int SETTLE_CYCLES = 128;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PIXELS = 400;
  localparam int IDLE_PERCENT  = 19;

  typedef struct packed {
    logic signed [csmm_pkg::PIX_W-1:0] sample;
    logic                              is_nan;
  } pixel_t;

  typedef struct packed {
    logic [csmm_pkg::DIM_W-1:0]        slice_number;
    logic signed [csmm_pkg::PIX_W-1:0] slice_min;
    logic signed [csmm_pkg::PIX_W-1:0] slice_max;
    logic                              slice_has_valid;
    logic                              cube_done;
    logic signed [csmm_pkg::PIX_W-1:0] cube_min;
    logic signed [csmm_pkg::PIX_W-1:0] cube_max;
    logic [csmm_pkg::COUNT_W-1:0]      bad_pixels;
    logic [csmm_pkg::COUNT_W-1:0]      good_pixels;
    logic [csmm_pkg::RMS_W-1:0]        rms_value;
  } slice_report_t;

  logic clk;
  logic rst;

  csmm_pix_if pix();
  csmm_res_if res();
  csmm_cfg_if cfg();

  cube_slice_min_max_rms_core DUT (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res),
    .cfg (cfg)
  );

  always #1 clk = ~clk;

  // Register copies as the block should see them
  logic [csmm_pkg::DIM_W-1:0] dim_columns;
  logic [csmm_pkg::DIM_W-1:0] dim_rows;
  logic [csmm_pkg::DIM_W-1:0] dim_slices;

  // Running statistics of the cube in progress
  logic [31:0]                       pix_count;
  logic [csmm_pkg::DIM_W-1:0]        slice_idx;
  logic signed [csmm_pkg::PIX_W-1:0] slc_min;
  logic signed [csmm_pkg::PIX_W-1:0] slc_max;
  logic                              slc_seen;
  logic signed [csmm_pkg::PIX_W-1:0] cube_lo;
  logic signed [csmm_pkg::PIX_W-1:0] cube_hi;
  logic [csmm_pkg::ACC_W-1:0]        sq_total;
  logic [csmm_pkg::COUNT_W-1:0]      good_count;
  logic [csmm_pkg::COUNT_W-1:0]      bad_count;

  pixel_t        pending_pixels[$];
  slice_report_t expected_reports[$];
  int            pixels_sent;
  int            pixels_taken;
  int            mismatches;
  int            cycle_count;
  logic          steady;

  function automatic logic [csmm_pkg::DIM_W-1:0] at_least_one(
    input logic [csmm_pkg::DIM_W-1:0] v);
    return (v == '0) ? csmm_pkg::DIM_W'(1) : v;
  endfunction

  // Floor of the square root, two bits of radicand per step
  function automatic logic [63:0] square_root(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] probe;
    rem   = x;
    root  = '0;
    probe = 64'h4000_0000_0000_0000;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  task automatic clear_slice_stats();
    pix_count = '0;
    slc_min   = csmm_pkg::MOST_POS;
    slc_max   = csmm_pkg::MOST_NEG;
    slc_seen  = 1'b0;
  endtask

  task automatic clear_cube_stats();
    clear_slice_stats();
    slice_idx  = '0;
    cube_lo    = csmm_pkg::MOST_POS;
    cube_hi    = csmm_pkg::MOST_NEG;
    sq_total   = '0;
    good_count = '0;
    bad_count  = '0;
  endtask

  // Fold one accepted pixel into the statistics; queue the slice report it completes
  task automatic absorb_pixel(input pixel_t px);
    logic signed [csmm_pkg::PIX_W-1:0] value;
    logic signed [63:0]      wide;
    logic [63:0]             square;
    logic [64:0]             grown;
    logic [31:0]             per_slice;
    logic [31:0]             eff_cols;
    logic [31:0]             eff_rows;
    logic [63:0]             root;
    logic                    last_slice;
    slice_report_t           rep;
    value = px.sample;
    if (px.is_nan || value == csmm_pkg::SENTINEL) begin
      if (bad_count != csmm_pkg::COUNT_MAX) bad_count = bad_count + csmm_pkg::COUNT_W'(1);
    end else begin
      wide   = 64'(value);
      square = wide * wide;
      if (value < slc_min) slc_min = value;
      if (value > slc_max) slc_max = value;
      if (value < cube_lo) cube_lo = value;
      if (value > cube_hi) cube_hi = value;
      slc_seen = 1'b1;
      grown    = {1'b0, sq_total} + {1'b0, square};
      sq_total = grown[64] ? {csmm_pkg::ACC_W{1'b1}} : grown[63:0];
      if (good_count != csmm_pkg::COUNT_MAX) good_count = good_count + csmm_pkg::COUNT_W'(1);
    end
    pix_count = pix_count + 32'd1;
    eff_cols  = 32'(at_least_one(dim_columns));
    eff_rows  = 32'(at_least_one(dim_rows));
    per_slice = eff_cols * eff_rows;
    if (pix_count >= per_slice) begin
      rep                 = '0;
      rep.slice_number    = slice_idx;
      rep.slice_min       = slc_min;
      rep.slice_max       = slc_max;
      rep.slice_has_valid = slc_seen;
      last_slice = ({1'b0, slice_idx} + 17'd1) >= {1'b0, at_least_one(dim_slices)};
      if (!last_slice) begin
        clear_slice_stats();
        slice_idx = slice_idx + csmm_pkg::DIM_W'(1);
      end else begin
        rep.cube_done   = 1'b1;
        rep.cube_min    = cube_lo;
        rep.cube_max    = cube_hi;
        rep.bad_pixels  = bad_count;
        rep.good_pixels = good_count;
        if (good_count != '0) begin
          root = square_root(sq_total / {16'b0, good_count});
          rep.rms_value = (root > 64'h7FFF_FFFF) ? csmm_pkg::RMS_MAX
                                                 : root[csmm_pkg::RMS_W-1:0];
        end
        clear_cube_stats();
      end
      expected_reports.push_back(rep);
    end
  endtask

  function automatic string describe(input slice_report_t r);
    return $sformatf({"slice %0d min %0d max %0d has_valid %0b done %0b cube_min %0d ",
                      "cube_max %0d bad %0d good %0d rms %0d"},
                     r.slice_number, r.slice_min, r.slice_max, r.slice_has_valid,
                     r.cube_done, r.cube_min, r.cube_max, r.bad_pixels, r.good_pixels,
                     r.rms_value);
  endfunction

  function automatic logic [csmm_pkg::DIM_W-1:0] random_dim();
    if ($urandom_range(19) == 0) return '0;
    return csmm_pkg::DIM_W'($urandom_range(4, 1));
  endfunction

  function automatic logic signed [csmm_pkg::PIX_W-1:0] random_sample();
    int pick;
    pick = $urandom_range(99);
    if (pick < 6) return csmm_pkg::SENTINEL;
    if (pick < 9) return csmm_pkg::MOST_POS;
    if (pick < 12) return csmm_pkg::MOST_NEG;
    if (pick < 15) return '0;
    if (pick < 45) return $urandom_range(2000) - 1000;
    return $urandom;
  endfunction

  task automatic send_pixel(input logic signed [csmm_pkg::PIX_W-1:0] sample,
                            input logic is_nan);
    pixel_t px;
    px.sample = sample;
    px.is_nan = is_nan;
    pending_pixels.push_back(px);
    pixels_sent++;
  endtask

  // Hold until every pixel is taken and every report has arrived, then let the tail finish
  task automatic settle();
    while (pixels_taken != pixels_sent || expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Keep valid high across back-to-back writes; the caller lowers it afterwards
  task automatic write_register(input logic [csmm_pkg::IDX_W-1:0] idx,
                                input logic [csmm_pkg::DIM_W-1:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      csmm_pkg::REG_COLUMNS: dim_columns = value;
      csmm_pkg::REG_ROWS:    dim_rows    = value;
      csmm_pkg::REG_SLICES:  dim_slices  = value;
      default: ;
    endcase
  endtask

  // Pixel driver: advance on each accepted transaction, idle at random
  always @(posedge clk) begin : pixel_driver
    pixel_t taken;
    pixel_t next_px;
    if (rst) begin
      pix.valid <= 1'b0;
    end else begin
      if (pix.valid && pix.ready) begin
        taken.sample = pix.sample;
        taken.is_nan = pix.is_nan;
        absorb_pixel(taken);
        pixels_taken++;
      end
      if (!pix.valid || pix.ready) begin
        if (pending_pixels.size() != 0 && (steady || $urandom_range(99) >= IDLE_PERCENT)) begin
          next_px = pending_pixels.pop_front();
          pix.valid  <= 1'b1;
          pix.sample <= next_px.sample;
          pix.is_nan <= next_px.is_nan;
        end else begin
          pix.valid <= 1'b0;
        end
      end
    end
  end

  // Report monitor: check each transaction against the oldest expectation
  always @(posedge clk) begin : report_monitor
    slice_report_t got;
    slice_report_t want;
    string         wrong;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        got.slice_number    = res.slice_number;
        got.slice_min       = res.slice_min;
        got.slice_max       = res.slice_max;
        got.slice_has_valid = res.slice_has_valid;
        got.cube_done       = res.cube_done;
        got.cube_min        = res.cube_min;
        got.cube_max        = res.cube_max;
        got.bad_pixels      = res.bad_pixels;
        got.good_pixels     = res.good_pixels;
        got.rms_value       = res.rms_value;
        if (expected_reports.size() == 0) begin
          if (mismatches < 10) $display("unexpected report: %s", describe(got));
          mismatches++;
        end else begin
          want  = expected_reports.pop_front();
          wrong = "";
          if (got.slice_number !== want.slice_number) wrong = {wrong, " slice_number"};
          if (got.slice_min !== want.slice_min) wrong = {wrong, " slice_min"};
          if (got.slice_max !== want.slice_max) wrong = {wrong, " slice_max"};
          if (got.slice_has_valid !== want.slice_has_valid) wrong = {wrong, " slice_has_valid"};
          if (got.cube_done !== want.cube_done) wrong = {wrong, " cube_done"};
          if (got.cube_min !== want.cube_min) wrong = {wrong, " cube_min"};
          if (got.cube_max !== want.cube_max) wrong = {wrong, " cube_max"};
          if (got.bad_pixels !== want.bad_pixels) wrong = {wrong, " bad_pixels"};
          if (got.good_pixels !== want.good_pixels) wrong = {wrong, " good_pixels"};
          if (got.rms_value !== want.rms_value) wrong = {wrong, " rms_value"};
          if (wrong != "") begin
            if (mismatches < 10) begin
              $display("report mismatch in:%s", wrong);
              $display("  expected %s", describe(want));
              $display("  actual   %s", describe(got));
            end
            mismatches++;
          end
        end
      end
      res.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int          phase;
    int          random_items;
    int          cube_len;
    int          count;
    logic [31:0] c_eff;
    logic [31:0] r_eff;
    logic [31:0] z_eff;
    clk          = 1'b0;
    rst          = 1'b1;
    steady       = 1'b0;
    cycle_count  = 0;
    pixels_sent  = 0;
    pixels_taken = 0;
    mismatches   = 0;
    pix.valid    = 1'b0;
    pix.sample   = '0;
    pix.is_nan   = 1'b0;
    res.ready    = 1'b0;
    cfg.valid    = 1'b0;
    cfg.index    = csmm_pkg::REG_COLUMNS;
    cfg.data     = '0;
    dim_columns  = csmm_pkg::DIM_W'(1);
    dim_rows     = csmm_pkg::DIM_W'(1);
    dim_slices   = csmm_pkg::DIM_W'(1);
    clear_cube_stats();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // One-pixel cubes: extremes, sentinel, NaN, and an RMS that saturates
    send_pixel('0, 1'b0);
    send_pixel(csmm_pkg::MOST_POS, 1'b0);
    send_pixel(csmm_pkg::MOST_NEG, 1'b0);
    send_pixel(-1, 1'b0);
    send_pixel(1, 1'b0);
    send_pixel(csmm_pkg::SENTINEL, 1'b0);
    send_pixel(5, 1'b1);
    send_pixel(csmm_pkg::SENTINEL, 1'b1);
    settle();

    // Zero rows and slices act as one; five full-scale squares saturate the sum
    write_register(csmm_pkg::REG_COLUMNS, csmm_pkg::DIM_W'(5));
    write_register(csmm_pkg::REG_ROWS, '0);
    write_register(csmm_pkg::REG_SLICES, '0);
    cfg.valid <= 1'b0;
    repeat (5) send_pixel(csmm_pkg::MOST_NEG, 1'b0);
    settle();

    // Largest sizes, then shrink them part way through the cube
    write_register(csmm_pkg::REG_COLUMNS, '1);
    write_register(csmm_pkg::REG_ROWS, '1);
    write_register(csmm_pkg::REG_SLICES, '1);
    cfg.valid <= 1'b0;
    send_pixel(100, 1'b0);
    send_pixel(3, 1'b1);
    send_pixel(-7, 1'b0);
    settle();
    write_register(csmm_pkg::REG_COLUMNS, csmm_pkg::DIM_W'(1));
    write_register(csmm_pkg::REG_ROWS, csmm_pkg::DIM_W'(1));
    cfg.valid <= 1'b0;
    send_pixel(-2, 1'b0);
    settle();
    write_register(csmm_pkg::REG_SLICES, csmm_pkg::DIM_W'(2));
    cfg.valid <= 1'b0;
    send_pixel(42, 1'b0);
    settle();

    // Two slices, the first with no valid pixel
    write_register(csmm_pkg::REG_ROWS, csmm_pkg::DIM_W'(2));
    cfg.valid <= 1'b0;
    send_pixel(9, 1'b1);
    send_pixel(csmm_pkg::SENTINEL, 1'b0);
    send_pixel(10, 1'b0);
    send_pixel(-10, 1'b0);
    settle();

    // Random cubes; now and then a broken cube leaves the next settings to land mid-cube
    phase        = 0;
    random_items = 0;
    while (random_items < RANDOM_PIXELS) begin
      phase++;
      steady = (phase >= 4 && phase <= 7);
      if ($urandom_range(3) != 0) write_register(csmm_pkg::REG_COLUMNS, random_dim());
      if ($urandom_range(3) != 0) write_register(csmm_pkg::REG_ROWS, random_dim());
      if ($urandom_range(3) != 0) write_register(csmm_pkg::REG_SLICES, random_dim());
      cfg.valid <= 1'b0;
      c_eff    = 32'(at_least_one(dim_columns));
      r_eff    = 32'(at_least_one(dim_rows));
      z_eff    = 32'(at_least_one(dim_slices));
      cube_len = c_eff * r_eff * z_eff;
      count    = cube_len * $urandom_range(3, 1);
      if ($urandom_range(9) == 0) count = count + $urandom_range(cube_len, 1);
      repeat (count) send_pixel(random_sample(), $urandom_range(99) < 8);
      random_items += count;
      settle();
    end
    steady = 1'b0;

    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
